/* rtl/core/thumbstick_turn_conditioner_macros.svh */
// Assertion macros for the thumbstick turn conditioner.
// Used by modules that have clk_i and rst_ni in scope.
`ifndef THUMBSTICK_TURN_CONDITIONER_MACROS_SVH
`define THUMBSTICK_TURN_CONDITIONER_MACROS_SVH

// Property must hold at every clock edge outside reset
`define TSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen outside reset
`define TSC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/core/tsc_pkg.sv */
// Shared types, constants and tables of the thumbstick turn conditioner.
// No dependencies; the front end, job queue, back end and top level import this package.
package tsc_pkg;

  // Queue between front and back
  localparam int unsigned JOB_DEPTH = 2;
  localparam int unsigned JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int unsigned JOB_CNT_W = $clog2(JOB_DEPTH + 1);

  // Iteration counts of the back-end sequencer
  localparam int unsigned DIV_STEPS   = 33;
  localparam int unsigned LOG_STEPS   = 16;
  localparam int unsigned EXP_STEPS   = 16;
  localparam int unsigned SCALE_STEPS = 4;

  // Turn scaling: Q16.8 rate, percent, ns and Q1.15 curve down to Q16.16
  localparam logic [43:0] TURN_DIV = 44'd12800000000000;
  localparam logic [8:0]  PCT_MIN  = 9'd1;
  localparam logic [8:0]  PCT_MAX  = 9'd500;

  // TURN_DIV = 2^18 * 5^11: shift out the power of two, then multiply the
  // 62-bit remainder by ceil(2^88 / 5^11) and keep bits 88 and up
  localparam int unsigned TURN_SHIFT = 18;
  localparam logic [25:0] TURN_ODD   = 26'(TURN_DIV >> TURN_SHIFT);
  localparam logic [62:0] TURN_RECIP =
    63'(((128'd1 << 88) + {102'd0, TURN_ODD} - 128'd1) / {102'd0, TURN_ODD});

  typedef enum logic [2:0] {
    CFG_DEADZONE   = 3'd0,
    CFG_CURVE_EXP  = 3'd1,
    CFG_TURN_RATE  = 3'd2,
    CFG_MAX_FRAME  = 3'd3,
    CFG_REARM      = 3'd4,
    CFG_FIRE       = 3'd5,
    CFG_SNAP_MIN   = 3'd6,
    CFG_SNAP_MAX   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] deadzone;
    logic [15:0] curve_exponent;
    logic [23:0] turn_rate;
    logic [31:0] max_frame_ns;
    logic [15:0] rearm_level;
    logic [16:0] fire_level;
    logic [8:0]  snap_min_deg;
    logic [8:0]  snap_max_deg;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    deadzone:       16'd6554,
    curve_exponent: 16'd256,
    turn_rate:      24'd46080,
    max_frame_ns:   32'd100000000,
    rearm_level:    16'd16384,
    fire_level:     17'd45875,
    snap_min_deg:   9'd15,
    snap_max_deg:   9'd90
  };

  typedef struct packed {
    logic               captured;
    logic               timing_gap;
    logic               smooth_done;
    logic               snap_done;
    logic [31:0]        frame_ns;
    logic signed [15:0] curve_out;
    logic signed [31:0] turn_degrees;
  } res_t;

  typedef enum logic {
    JOB_DIRECT = 1'b0,
    JOB_SMOOTH = 1'b1
  } job_kind_e;

  // Classified request handed from front to back
  typedef struct packed {
    job_kind_e   kind;
    res_t        res;
    logic [16:0] mag;
    logic        neg;
    logic [8:0]  pct;
  } job_t;

  // Table of 2^-(2^-(i+1)) in Q32, built by repeated floor square roots
  typedef logic [31:0] exp_tab_t [EXP_STEPS];

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bw;
    logic [63:0] rem;
    res = '0;
    bw  = 64'h4000_0000_0000_0000;
    rem = v;
    for (int s = 0; s < 32; s++) begin
      if (rem >= res + bw) begin
        rem = rem - (res + bw);
        res = (res >> 1) + bw;
      end else begin
        res = res >> 1;
      end
      bw = bw >> 2;
    end
    return res;
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    t;
    logic [63:0] prev;
    prev = isqrt64(64'h8000_0000_0000_0000);
    t[0] = prev[31:0];
    for (int i = 1; i < EXP_STEPS; i++) begin
      prev = isqrt64({prev[31:0], 32'h0});
      t[i] = prev[31:0];
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

/* rtl/core/tsc_if.sv */
// Channel interfaces of the thumbstick turn conditioner: frame in, turn out, config.
// Stand-alone; no package needed.
interface tsc_frame_if;
  logic               valid;
  logic               ready;
  logic               turn_enable;
  logic               smooth_select;
  logic               stick_active;
  logic               menu_held;
  logic signed [15:0] stick_x;
  logic [15:0]        speed_percent;
  logic [15:0]        snap_angle;
  logic signed [63:0] display_time_ns;
  logic [31:0]        life_token;

  modport source (output valid, turn_enable, smooth_select, stick_active, menu_held,
                  stick_x, speed_percent, snap_angle, display_time_ns, life_token,
                  input ready);
  modport sink (input valid, turn_enable, smooth_select, stick_active, menu_held,
                stick_x, speed_percent, snap_angle, display_time_ns, life_token,
                output ready);
endinterface

interface tsc_turn_if;
  logic               valid;
  logic               ready;
  logic               captured;
  logic               timing_gap;
  logic               smooth_done;
  logic               snap_done;
  logic [31:0]        frame_ns;
  logic signed [15:0] curve_out;
  logic signed [31:0] turn_degrees;

  modport source (output valid, captured, timing_gap, smooth_done, snap_done, frame_ns,
                  curve_out, turn_degrees, input ready);
  modport sink (input valid, captured, timing_gap, smooth_done, snap_done, frame_ns,
                curve_out, turn_degrees, output ready);
endinterface

interface tsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/tsc_front.sv */
// Front end: accepts frame requests, tracks life/mode/time state, classifies work.
// Depends on tsc_pkg and tsc_frame_if.
module tsc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  tsc_frame_if.sink     frame_i,
  input  tsc_pkg::cfg_t cfg_i,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output tsc_pkg::job_t job_o
);
  import tsc_pkg::*;

  logic        trk_q, mode_q, armed_q;
  logic [31:0] tok_q;
  logic [63:0] last_q;

  logic        trk_d, mode_d, armed_d;
  logic [31:0] tok_d;
  logic [63:0] last_d;

  logic        accept;
  logic        cfg_ok, clear, capture;
  logic        neg;
  logic [16:0] abs17;
  logic [16:0] mag;
  logic [63:0] t_u;
  logic [63:0] elapsed;
  logic [8:0]  pct;
  logic [8:0]  snap_a;
  logic [31:0] snap_v;
  job_t        job;

  assign frame_i.ready = job_ready_i;
  assign job_valid_o   = frame_i.valid;
  assign accept        = frame_i.valid & job_ready_i;
  assign job_o         = job;

  // Configuration sanity
  assign cfg_ok = (cfg_i.curve_exponent != '0) && (cfg_i.turn_rate != '0) &&
                  (cfg_i.max_frame_ns != '0) &&
                  ({1'b0, cfg_i.rearm_level} < cfg_i.fire_level) &&
                  (cfg_i.fire_level <= 17'h10000) &&
                  (cfg_i.snap_min_deg != '0) &&
                  (cfg_i.snap_min_deg <= cfg_i.snap_max_deg);

  // Stick magnitude, Q1.16
  assign neg   = frame_i.stick_x[15];
  assign abs17 = neg ? (17'h10000 - {1'b0, frame_i.stick_x}) : {1'b0, frame_i.stick_x};
  assign mag   = {abs17[15:0], 1'b0};

  assign t_u     = frame_i.display_time_ns;
  assign elapsed = (t_u > last_q) ? (t_u - last_q) : 64'd0;

  // Speed clamp and snap angle clamp
  always_comb begin
    if (frame_i.speed_percent < {7'd0, PCT_MIN}) begin
      pct = PCT_MIN;
    end else if (frame_i.speed_percent > {7'd0, PCT_MAX}) begin
      pct = PCT_MAX;
    end else begin
      pct = frame_i.speed_percent[8:0];
    end
    if (frame_i.snap_angle < {7'd0, cfg_i.snap_min_deg}) begin
      snap_a = cfg_i.snap_min_deg;
    end else if (frame_i.snap_angle > {7'd0, cfg_i.snap_max_deg}) begin
      snap_a = cfg_i.snap_max_deg;
    end else begin
      snap_a = frame_i.snap_angle[8:0];
    end
  end

  assign snap_v = neg ? (32'd0 - {7'd0, snap_a, 16'd0}) : {7'd0, snap_a, 16'd0};

  assign clear = !frame_i.turn_enable || (frame_i.life_token == '0) ||
                 (t_u == '0) || t_u[63] || !cfg_ok;
  assign capture = !trk_q || (tok_q != frame_i.life_token) ||
                   (mode_q != frame_i.smooth_select);

  // Classification and next state
  always_comb begin
    trk_d   = trk_q;
    mode_d  = mode_q;
    armed_d = armed_q;
    tok_d   = tok_q;
    last_d  = last_q;
    job      = '0;
    job.kind = JOB_DIRECT;
    job.mag  = mag;
    job.neg  = neg;
    job.pct  = pct;
    if (clear) begin
      trk_d   = 1'b0;
      mode_d  = 1'b0;
      armed_d = 1'b0;
      tok_d   = '0;
      last_d  = '0;
    end else if (capture) begin
      trk_d   = 1'b1;
      mode_d  = frame_i.smooth_select;
      armed_d = 1'b1;
      tok_d   = frame_i.life_token;
      last_d  = t_u;
      job.res.captured = 1'b1;
    end else begin
      last_d = t_u;
      if (frame_i.smooth_select) begin
        if (elapsed == '0) begin
          job.res = '0;
        end else if (elapsed > {32'd0, cfg_i.max_frame_ns}) begin
          job.res.timing_gap = 1'b1;
        end else begin
          job.res.frame_ns = elapsed[31:0];
          if (frame_i.stick_active && !frame_i.menu_held &&
              (mag > {1'b0, cfg_i.deadzone})) begin
            job.kind = JOB_SMOOTH;
          end
        end
      end else begin
        if (!frame_i.stick_active || (mag < {1'b0, cfg_i.rearm_level})) begin
          armed_d = 1'b1;
        end else if (!frame_i.menu_held && armed_q && (mag >= cfg_i.fire_level)) begin
          job.res.turn_degrees = snap_v;
          job.res.snap_done    = 1'b1;
          armed_d = 1'b0;
        end
      end
    end
  end

  // Tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_q   <= 1'b0;
      mode_q  <= 1'b0;
      armed_q <= 1'b0;
      tok_q   <= '0;
      last_q  <= '0;
    end else if (accept) begin
      trk_q   <= trk_d;
      mode_q  <= mode_d;
      armed_q <= armed_d;
      tok_q   <= tok_d;
      last_q  <= last_d;
    end
  end

endmodule

/* rtl/core/tsc_job_fifo.sv */
// Short job queue between the front end and the back end.
// Depends on tsc_pkg for the job type and depth.
module tsc_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  tsc_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output tsc_pkg::job_t pop_data_o
);
  import tsc_pkg::*;

  job_t                 mem_q [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_q, rd_q;
  logic [JOB_CNT_W-1:0] cnt_q;
  logic                 push, pop;

  assign push_ready_o = (cnt_q != JOB_CNT_W'(JOB_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/tsc_back.sv */
// Back end: sequencer that normalizes, shapes and scales smooth turns; direct results
// go straight to the output register. Depends on tsc_pkg and the assertion macro header.
`include "thumbstick_turn_conditioner_macros.svh"

module tsc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_pop_o,
  input  tsc_pkg::job_t job_i,
  input  tsc_pkg::cfg_t cfg_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tsc_pkg::res_t out_o
);
  import tsc_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_DIV   = 13'b0000000000010,
    S_NORM  = 13'b0000000000100,
    S_LOG   = 13'b0000000001000,
    S_POW   = 13'b0000000010000,
    S_EXP   = 13'b0000000100000,
    S_CURVE = 13'b0000001000000,
    S_RATE  = 13'b0000010000000,
    S_PCT   = 13'b0000100000000,
    S_TLO   = 13'b0001000000000,
    S_THI   = 13'b0010000000000,
    S_TDIV  = 13'b0100000000000,
    S_SAT   = 13'b1000000000000
  } back_state_e;

  back_state_e state_q, state_d;
  logic [6:0]  cnt_q;
  logic        neg_q;
  logic [8:0]  pct_q;
  logic [31:0] frame_q;
  logic [32:0] num_q;
  logic [16:0] rem_q;
  logic [16:0] n_q;
  logic        lzero_q;
  logic [3:0]  k_q;
  logic [16:0] m_q;
  logic [15:0] frac_q;
  logic [6:0]  ip_q;
  logic [15:0] fp_q;
  logic [32:0] acc_q;
  logic [14:0] resp_q;
  logic [79:0] prod_q;
  logic [55:0] tmp_q;
  logic [65:0] racc_q;
  logic [36:0] q_q;
  logic        out_valid_q;
  res_t        out_q;

  logic        out_free, load_out;
  res_t        res_d;
  logic [16:0] den;
  logic [16:0] sub_mag;
  logic [17:0] div_sh;
  logic        div_ge;
  logic [3:0]  lz;
  logic [33:0] sq;
  logic [4:0]  l_int;
  logic [20:0] l_val;
  logic [36:0] p_prod;
  logic [12:0] ip_raw;
  logic [64:0] e_prod;
  logic [32:0] shv;
  logic [15:0] crv;
  logic [14:0] resp;
  logic [38:0] p_rate;
  logic [47:0] p_pct;
  logic [55:0] p_lo, p_hi;
  logic [79:0] p_sum;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [65:0] rsum;
  logic [65:0] racc_d;
  logic [36:0] q_sat;
  logic [31:0] turn_v;

  function automatic logic [3:0] lead_zeros(input logic [15:0] v);
    logic [3:0] z;
    logic       found;
    z     = '0;
    found = 1'b0;
    for (int b = 15; b >= 0; b--) begin
      if (v[b]) begin
        found = 1'b1;
      end else if (!found) begin
        z = z + 4'd1;
      end
    end
    return z;
  endfunction

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Normalizing divide: one quotient bit per cycle
  assign den     = 17'h10000 - {1'b0, cfg_i.deadzone};
  assign sub_mag = job_i.mag - {1'b0, cfg_i.deadzone};
  assign div_sh  = {rem_q, num_q[32]};
  assign div_ge  = div_sh >= {1'b0, den};

  // Log2 by repeated squaring
  assign lz = lead_zeros(n_q[15:0]);
  assign sq = {17'd0, m_q} * {17'd0, m_q};

  // Exponent product L*e
  assign l_int  = {1'b0, k_q} + 5'd1;
  assign l_val  = lzero_q ? 21'd0 : ({l_int, 16'd0} - {5'd0, frac_q});
  assign p_prod = {16'd0, l_val} * {21'd0, cfg_i.curve_exponent};
  assign ip_raw = p_prod[36:24];

  // Power of two, one table factor per cycle
  assign e_prod = {32'd0, acc_q} * {33'd0, EXP_TAB[cnt_q[3:0]]};

  // Shaped response, Q1.15
  assign shv  = (ip_q >= 7'd33) ? 33'd0 : (acc_q >> ip_q);
  assign crv  = shv[32:17];
  assign resp = (crv > 16'd32767) ? 15'h7FFF : crv[14:0];

  // Turn scaling products
  assign p_rate = {24'd0, resp_q} * {15'd0, cfg_i.turn_rate};
  assign p_pct  = {9'd0, prod_q[38:0]} * {39'd0, pct_q};
  assign p_lo   = {32'd0, prod_q[23:0]} * {24'd0, frame_q};
  assign p_hi   = {32'd0, prod_q[47:24]} * {24'd0, frame_q};
  assign p_sum  = {24'd0, tmp_q} + {p_hi, 24'd0};

  // Constant divide by reciprocal: four 32x32 partial products, low word first
  assign mul_a = cnt_q[1] ? {2'd0, prod_q[79:50]} : prod_q[49:18];
  assign mul_b = cnt_q[0] ? {1'b0, TURN_RECIP[62:32]} : TURN_RECIP[31:0];
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    rsum = racc_q + {2'd0, mul_p};
    case (cnt_q[1:0])
      2'd0:    racc_d = {34'd0, mul_p[63:32]};
      2'd2:    racc_d = {32'd0, rsum[65:32]};
      default: racc_d = rsum;
    endcase
  end

  // Saturate and sign the turn
  always_comb begin
    if (neg_q) begin
      q_sat  = (q_q > 37'h0080000000) ? 37'h0080000000 : q_q;
      turn_v = 32'd0 - q_sat[31:0];
    end else begin
      q_sat  = (q_q > 37'h007FFFFFFF) ? 37'h007FFFFFFF : q_q;
      turn_v = q_sat[31:0];
    end
  end

  // Sequencer control and output load
  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    load_out  = 1'b0;
    res_d     = job_i.res;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          if (job_i.kind == JOB_SMOOTH) begin
            job_pop_o = 1'b1;
            state_d   = S_DIV;
          end else if (out_free) begin
            job_pop_o = 1'b1;
            load_out  = 1'b1;
          end
        end
      end
      S_DIV:   if (cnt_q == 7'(DIV_STEPS - 1)) state_d = S_NORM;
      S_NORM:  state_d = n_q[16] ? S_POW : S_LOG;
      S_LOG:   if (cnt_q == 7'(LOG_STEPS - 1)) state_d = S_POW;
      S_POW:   state_d = S_EXP;
      S_EXP:   if (cnt_q == 7'(EXP_STEPS - 1)) state_d = S_CURVE;
      S_CURVE: state_d = (resp == '0) ? S_SAT : S_RATE;
      S_RATE:  state_d = S_PCT;
      S_PCT:   state_d = S_TLO;
      S_TLO:   state_d = S_THI;
      S_THI:   state_d = S_TDIV;
      S_TDIV:  if (cnt_q == 7'(SCALE_STEPS - 1)) state_d = S_SAT;
      S_SAT: begin
        res_d              = '0;
        res_d.frame_ns     = frame_q;
        res_d.curve_out    = neg_q ? (16'd0 - {1'b0, resp_q}) : {1'b0, resp_q};
        res_d.turn_degrees = (q_q == '0) ? 32'd0 : turn_v;
        res_d.smooth_done  = (q_q != '0);
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_d != state_q) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + 7'd1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= res_d;
    end
    case (state_q)
      S_IDLE: begin
        neg_q   <= job_i.neg;
        pct_q   <= job_i.pct;
        frame_q <= job_i.res.frame_ns;
        num_q   <= {sub_mag, 16'd0};
        rem_q   <= '0;
        n_q     <= '0;
      end
      S_DIV: begin
        rem_q <= div_ge ? 17'(div_sh - {1'b0, den}) : div_sh[16:0];
        n_q   <= {n_q[15:0], div_ge};
        num_q <= {num_q[31:0], 1'b0};
      end
      S_NORM: begin
        lzero_q <= n_q[16];
        k_q     <= lz;
        m_q     <= {16'(n_q[15:0] << lz), 1'b0};
        frac_q  <= '0;
      end
      S_LOG: begin
        m_q    <= sq[33] ? sq[33:17] : sq[32:16];
        frac_q <= {frac_q[14:0], sq[33]};
      end
      S_POW: begin
        ip_q  <= (ip_raw > 13'd64) ? 7'd64 : ip_raw[6:0];
        fp_q  <= p_prod[23:8];
        acc_q <= 33'h1_0000_0000;
      end
      S_EXP: begin
        if (fp_q[15]) begin
          acc_q <= e_prod[64:32];
        end
        fp_q <= {fp_q[14:0], 1'b0};
      end
      S_CURVE: begin
        resp_q <= resp;
        q_q    <= '0;
      end
      S_RATE:  prod_q <= {41'd0, p_rate};
      S_PCT:   prod_q <= {32'd0, p_pct};
      S_TLO:   tmp_q  <= p_lo;
      S_THI: begin
        prod_q <= p_sum;
        racc_q <= '0;
        q_q    <= '0;
      end
      S_TDIV: begin
        racc_q <= racc_d;
        q_q    <= racc_d[60:24];
      end
      default: ;
    endcase
  end

  `TSC_ASSERT(a_pop_idle, job_pop_o |-> (state_q == S_IDLE), "job taken while sequencer busy")
  `TSC_ASSERT(a_no_overwrite, load_out |-> out_free, "pending result overwritten")
  `TSC_ASSERT(a_done_turn, (load_out && res_d.smooth_done) |-> (res_d.turn_degrees != 32'sd0), "smooth_done with zero turn")
  `TSC_ASSERT(a_sat_wait, ((state_q == S_SAT) && !out_free) |=> (state_q == S_SAT), "result dropped while output stalled")

endmodule

/* rtl/core/thumbstick_turn_conditioner.sv */
// Thumbstick turn conditioner: one frame request in, one turn result out, per frame.
// Frame requests are classified at once by the front end and queued (two entries); a
// result that needs no curve goes from the queue head into the output register once
// the sequencer is idle and the output register is free. A smooth turn with the stick
// past the deadzone runs through the back-end sequencer: a bit-serial normalizing
// divide, 16 squaring steps for log2, 16 table steps for exp2, four multiply steps and
// a four-step reciprocal multiply for the divide by the turn scale constant.
// Configuration writes are taken any cycle.
// Depends on tsc_pkg, tsc_if, tsc_front, tsc_job_fifo and tsc_back.
module thumbstick_turn_conditioner (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsc_frame_if.sink  frame_i,
  tsc_turn_if.source turn_o,
  tsc_cfg_if.sink    cfg_i
);
  import tsc_pkg::*;

  cfg_t cfg_q;
  job_t front_job, fifo_job;
  res_t res;
  logic front_valid, fifo_ready;
  logic fifo_valid, fifo_pop;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_DEADZONE:  cfg_q.deadzone       <= cfg_i.data[15:0];
        CFG_CURVE_EXP: cfg_q.curve_exponent <= cfg_i.data[15:0];
        CFG_TURN_RATE: cfg_q.turn_rate      <= cfg_i.data[23:0];
        CFG_MAX_FRAME: cfg_q.max_frame_ns   <= cfg_i.data;
        CFG_REARM:     cfg_q.rearm_level    <= cfg_i.data[15:0];
        CFG_FIRE:      cfg_q.fire_level     <= cfg_i.data[16:0];
        CFG_SNAP_MIN:  cfg_q.snap_min_deg   <= cfg_i.data[8:0];
        CFG_SNAP_MAX:  cfg_q.snap_max_deg   <= cfg_i.data[8:0];
        default: ;
      endcase
    end
  end

  tsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_i     (frame_i),
    .cfg_i       (cfg_q),
    .job_valid_o (front_valid),
    .job_ready_i (fifo_ready),
    .job_o       (front_job)
  );

  tsc_job_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (fifo_ready),
    .push_data_i  (front_job),
    .pop_valid_o  (fifo_valid),
    .pop_ready_i  (fifo_pop),
    .pop_data_o   (fifo_job)
  );

  tsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (fifo_valid),
    .job_pop_o   (fifo_pop),
    .job_i       (fifo_job),
    .cfg_i       (cfg_q),
    .out_valid_o (turn_o.valid),
    .out_ready_i (turn_o.ready),
    .out_o       (res)
  );

  // Result fields onto the output channel
  assign turn_o.captured     = res.captured;
  assign turn_o.timing_gap   = res.timing_gap;
  assign turn_o.smooth_done  = res.smooth_done;
  assign turn_o.snap_done    = res.snap_done;
  assign turn_o.frame_ns     = res.frame_ns;
  assign turn_o.curve_out    = res.curve_out;
  assign turn_o.turn_degrees = res.turn_degrees;

endmodule
